// File: rtl/swmf_pkg.sv
// shared types and constants for the sliding window median filter
package swmf_pkg;

	// defaults for the top level parameters
	localparam int WINDOW_MAX_DEF   = 16;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = REG_IDX_W'(0);

	// window size register
	localparam int WSIZE_W = 5;
	localparam logic [WSIZE_W-1:0] WSIZE_RST = WSIZE_W'(5);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CHECK
	} swmf_state_t;

	// controls for the rank count unit, aligned with the store read data
	typedef struct packed {
		logic load;  // read data is the candidate, restart the counts
		logic cmp;   // read data is compared against the candidate
	} swmf_rank_ctl_t;

endpackage

// File: rtl/swmf_window_mem.sv
// circular window store: one write port, one registered read port, zero for unwritten entries
module swmf_window_mem #(
	parameter int DEPTH = swmf_pkg::WINDOW_MAX_DEF,
	parameter int WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	import swmf_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// entries never written since the last clear read as zero
	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] ? mem_q[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/swmf_rank_unit.sv
// shared compare unit: counts window entries below and equal to one candidate
module swmf_rank_unit #(
	parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF,
	parameter int CNT_W        = 5
) (
	input  logic                           clk,
	input  swmf_pkg::swmf_rank_ctl_t       ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] rd_data,
	input  logic [CNT_W-1:0]               k,
	output logic signed [SAMPLE_WIDTH-1:0] cand,
	output logic                           hit
);
	import swmf_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] cand_q;
	logic [CNT_W-1:0]               below_q;
	logic [CNT_W-1:0]               equal_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cand_q  <= rd_data;
			below_q <= '0;
			equal_q <= '0;
		end else if (ctl.cmp) begin
			if (rd_data < cand_q) begin
				below_q <= below_q + CNT_W'(1);
			end else if (rd_data == cand_q) begin
				equal_q <= equal_q + CNT_W'(1);
			end
		end
	end

	// candidate holds rank k when k falls inside its run of equal values
	assign hit  = (below_q <= k) && (k < (below_q + equal_q));
	assign cand = cand_q;

endmodule

// File: rtl/sliding_window_median_filter.sv
// top level of the sliding window median filter: sequencer, config port and output register
//
// Each input beat carries one signed sample. It is written into a circular window of
// window_size entries (0 acts as 1, values above WINDOW_MAX saturate), the write position
// advances, and one output beat returns the window median: the value of rank floor(n/2)
// counting from zero, so an even window gives the upper middle value. Entries not written
// since reset or the last window_size write count as zero; writing window_size clears the
// window and the write position. The median is found by a rank count through one shared
// comparator: for each candidate entry in turn the sequencer reads the whole window from the
// single read port of the store, and the first candidate whose rank run covers floor(n/2)
// is the result. Each candidate takes a scan that reads it and then every entry, a drain
// state for the read latency and a check state; the store read port paces it. s_tready is
// high only while the block is idle; a finished median sits in the output register, so a
// new sample is taken while the previous result still waits for m_tready. window_size lies
// at byte address 0 of the configuration port and reads back; writes to other addresses
// are dropped.
module sliding_window_median_filter #(
	parameter int WINDOW_MAX   = swmf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF,
	parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [DATA_W-1:0]           s_tdata,    // [SAMPLE_WIDTH-1:0] sample, zero pad above
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [DATA_W-1:0]           m_tdata,    // [SAMPLE_WIDTH-1:0] median, zero pad above
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swmf_pkg::APB_AW-1:0] paddr,
	input  logic [swmf_pkg::APB_DW-1:0] pwdata,
	output logic [swmf_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import swmf_pkg::*;

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int SZ_W  = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

	// configuration register
	logic [WSIZE_W-1:0]   wsize_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	// sequencer state
	swmf_state_t          state_q, state_d;
	logic [CNT_W-1:0]     cand_idx_q, cand_idx_d;   // entry under test
	logic [CNT_W-1:0]     slot_q, slot_d;           // read slot: candidate, then every entry
	logic [IDX_W-1:0]     wp_q;
	swmf_rank_ctl_t       ctl_s1;
	logic                 last_s1;

	// window size and derived rank
	logic [SZ_W-1:0]      wsize_ext;
	logic [CNT_W-1:0]     n_eff;
	logic [CNT_W-1:0]     k_rank;
	logic [IDX_W-1:0]     wp_eff;
	logic [CNT_W-1:0]     wp_inc;

	// datapath handshakes
	logic                 in_acc;
	logic                 issue;
	logic [IDX_W-1:0]     raddr;
	logic [CNT_W-1:0]     slot_m1;
	logic [SAMPLE_WIDTH-1:0] rdata;
	logic signed [SAMPLE_WIDTH-1:0] cand;
	logic                 hit;
	logic                 out_free;
	logic                 out_load;
	logic                 m_tvalid_q;
	logic [SAMPLE_WIDTH-1:0] m_tdata_q;

	// ---------------------------------------------------------------
	// configuration port, no wait states
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_WINDOW_SIZE);
	assign prdata  = (reg_idx == REG_WINDOW_SIZE) ? APB_DW'(wsize_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= WSIZE_RST;
		end else if (cfg_wr) begin
			wsize_q <= pwdata[WSIZE_W-1:0];
		end
	end

	// effective window size: zero acts as one, large values saturate
	always_comb begin
		wsize_ext = SZ_W'(wsize_q);
		if (wsize_ext == '0) begin
			n_eff = CNT_W'(1);
		end else if (wsize_ext > SZ_W'(WINDOW_MAX)) begin
			n_eff = CNT_W'(WINDOW_MAX);
		end else begin
			n_eff = wsize_ext[CNT_W-1:0];
		end
	end

	assign k_rank = n_eff >> 1;

	// ---------------------------------------------------------------
	// write position, wraps at the effective size
	// ---------------------------------------------------------------
	assign in_acc = s_tvalid && s_tready;
	assign wp_eff = (CNT_W'(wp_q) >= n_eff) ? '0 : wp_q;
	assign wp_inc = CNT_W'(wp_eff) + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (cfg_wr) begin
			wp_q <= '0;
		end else if (in_acc) begin
			wp_q <= (wp_inc == n_eff) ? '0 : wp_inc[IDX_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cand_idx_q <= '0;
			slot_q     <= '0;
			ctl_s1     <= '0;
			last_s1    <= 1'b0;
		end else begin
			state_q    <= state_d;
			cand_idx_q <= cand_idx_d;
			slot_q     <= slot_d;
			// tag is registered alongside the store read data
			ctl_s1.load <= issue && (slot_q == '0);
			ctl_s1.cmp  <= issue && (slot_q != '0);
			last_s1     <= issue && (slot_q == n_eff);
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign slot_m1  = slot_q - CNT_W'(1);
	// slot zero fetches the candidate, slot s fetches entry s-1
	assign raddr    = (slot_q == '0) ? cand_idx_q[IDX_W-1:0] : slot_m1[IDX_W-1:0];

	always_comb begin
		state_d    = state_q;
		cand_idx_d = cand_idx_q;
		slot_d     = slot_q;
		issue      = 1'b0;
		out_load   = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cand_idx_d = '0;
					slot_d     = '0;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue  = 1'b1;
				slot_d = slot_q + CNT_W'(1);
				if (slot_q == n_eff) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last compare lands in the rank unit at the end of this cycle
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (hit) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					cand_idx_d = cand_idx_q + CNT_W'(1);
					slot_d     = '0;
					state_d    = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// window store and shared rank unit
	// ---------------------------------------------------------------
	swmf_window_mem #(
		.DEPTH (WINDOW_MAX),
		.WIDTH (SAMPLE_WIDTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_wr),
		.we     (in_acc),
		.waddr  (wp_eff),
		.wdata  (s_tdata[SAMPLE_WIDTH-1:0]),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	swmf_rank_unit #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.CNT_W        (CNT_W)
	) u_rank (
		.clk     (clk),
		.ctl     (ctl_s1),
		.rd_data (rdata),
		.k       (k_rank),
		.cand    (cand),
		.hit     (hit)
	);

	// ---------------------------------------------------------------
	// output register, holds a median until the beat is taken
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= cand;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'(m_tdata_q);

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN) && (cand_idx_q == '0) && (slot_q == '0))
		else $error("accepted sample did not start a scan at the first candidate");

	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |-> (state_q == ST_DRAIN))
		else $error("last compare arrived outside the drain cycle");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (slot_q <= n_eff) && (cand_idx_q < n_eff))
		else $error("scan slot or candidate beyond the window");

	a_cfg_clears_wp: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (wp_q == '0))
		else $error("window size write did not clear the write position");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid && (m_tdata_q == $past(cand)))
		else $error("median not captured in the output register");

endmodule

// File: bench/swmf_checker.sv
// checker for the sliding window median filter: predicts each median and compares output beats
module swmf_checker #(
	parameter int WINDOW_MAX = swmf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_W   = swmf_pkg::SAMPLE_WIDTH_DEF,
	parameter int DATA_W     = ((SAMPLE_W + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [DATA_W-1:0]           s_tdata,   // [SAMPLE_W-1:0] sample
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [DATA_W-1:0]           m_tdata,   // [SAMPLE_W-1:0] median
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swmf_pkg::APB_AW-1:0] paddr,
	input  logic [swmf_pkg::APB_DW-1:0] pwdata,
	input  logic [swmf_pkg::APB_DW-1:0] prdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          medians_seen,
	output int                          medians_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import swmf_pkg::*;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	sample_t              win_store [WINDOW_MAX];
	int                   win_pos;
	logic [WSIZE_W-1:0]   win_size_reg;
	sample_t              median_fifo [$];
	int                   err_count;
	int                   seen_count;

	// 0 behaves as 1, oversize saturates
	function automatic int active_span();
		if (win_size_reg == '0)
			return 1;
		if (win_size_reg > WINDOW_MAX)
			return WINDOW_MAX;
		return int'(win_size_reg);
	endfunction

	// sort the live part of the window, upper middle for even sizes
	function automatic sample_t window_median(input int n);
		sample_t srt [WINDOW_MAX];
		sample_t key;
		int j;
		for (int i = 0; i < n; i++) begin
			key = win_store[i];
			j = i;
			while (j > 0 && srt[j-1] > key) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = key;
		end
		return srt[n/2];
	endfunction

	task automatic clear_window();
		for (int i = 0; i < WINDOW_MAX; i++)
			win_store[i] = '0;
		win_pos = 0;
	endtask

	task automatic log_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		err_count++;
		if (err_count <= 10)
			$display("mismatch %0d at %0t ns: %s expected 0x%0h got 0x%0h",
				err_count, $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int n;
		sample_t want;
		logic [SAMPLE_W-1:0] got;
		if (!arst_n) begin
			win_size_reg = WSIZE_RST;
			clear_window();
			median_fifo.delete();
			err_count = 0;
			seen_count = 0;
		end else begin
			// register port
			if (psel && penable && pready && paddr[APB_AW-1:2] == REG_WINDOW_SIZE) begin
				if (pwrite) begin
					win_size_reg = pwdata[WSIZE_W-1:0];
					clear_window();
				end else if (prdata !== APB_DW'(win_size_reg)) begin
					log_mismatch("window_size readback", APB_DW'(win_size_reg), prdata);
				end
			end
			// output side first so a beat in the same cycle cannot pair with its own sample
			if (m_tvalid && m_tready) begin
				got = m_tdata[SAMPLE_W-1:0];
				seen_count++;
				if (median_fifo.size() == 0) begin
					log_mismatch("median beat with none pending", 0, 32'(got));
				end else begin
					want = median_fifo.pop_front();
					if (got !== want)
						log_mismatch("median", 32'(unsigned'(want)), 32'(got));
				end
			end
			if (s_tvalid && s_tready) begin
				n = active_span();
				if (win_pos >= n)
					win_pos = 0;
				win_store[win_pos] = s_tdata[SAMPLE_W-1:0];
				win_pos = (win_pos + 1) % n;
				median_fifo.push_back(window_median(n));
			end
		end
		mismatches   <= err_count;
		medians_seen <= seen_count;
		medians_due  <= median_fifo.size();
	end

endmodule

// File: bench/sliding_window_median_filter_tb.sv
// testbench top for the sliding window median filter: stimulus, stalls, watchdog and verdict
module sliding_window_median_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swmf_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 5;
	localparam int SAMPLE_W     = SAMPLE_WIDTH_DEF;
	localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1500;
	// covers the longest item at 16 entries, plus the longest stalls
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 320;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [APB_AW-1:0] ADDR_WSIZE = {REG_WINDOW_SIZE, 2'b00};
	// first index past the register list, writes there must be dropped
	localparam logic [APB_AW-1:0] ADDR_SPARE = {~REG_WINDOW_SIZE, 2'b00};

	localparam logic [SAMPLE_W-1:0] S_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] S_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [SAMPLE_W-1:0] S_ZERO = '0;
	localparam logic [SAMPLE_W-1:0] S_NEG1 = '1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [DATA_W-1:0]  s_tdata = '0;     // [SAMPLE_W-1:0] sample
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [DATA_W-1:0]  m_tdata;          // [SAMPLE_W-1:0] median
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	int mismatches;
	int medians_seen;
	int medians_due;

	int  samples_sent = 0;
	int  reg_writes = 0;
	int  idle_cycles = 0;
	bit  quiet_src = 1'b0;    // sender runs without gaps
	bit  quiet_sink = 1'b0;   // receiver never stalls
	int  sink_hold = 0;

	always #(CLK_PERIOD/2) clk = ~clk;

	sliding_window_median_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	swmf_checker #(
		.SAMPLE_W (SAMPLE_W),
		.DATA_W   (DATA_W)
	) median_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.medians_seen (medians_seen),
		.medians_due  (medians_due)
	);

	// gap length: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// full range values, a narrow band for ties, and the extremes
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return SAMPLE_W'($urandom());
		if (r < 80)
			return SAMPLE_W'($urandom_range(0, 6) - 3);
		if (r < 92) begin
			case ($urandom_range(0, 3))
				0: return S_MAX;
				1: return S_MIN;
				2: return S_ZERO;
				default: return S_NEG1;
			endcase
		end
		if (r < 96)
			return S_MAX - SAMPLE_W'($urandom_range(0, 3));
		return S_MIN + SAMPLE_W'($urandom_range(0, 3));
	endfunction

	// receiver: random stalls, with stretches of constant ready
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 299) == 0)
				quiet_sink <= ~quiet_sink;
			if (sink_hold != 0) begin
				sink_hold <= sink_hold - 1;
				m_tready <= 1'b0;
			end else if (!quiet_sink && $urandom_range(0, 3) == 0) begin
				sink_hold <= gap_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles where no beat and no register access completes
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("sliding_window_median_filter_tb failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// one sample beat, with an optional gap ahead of it
	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		int gap;
		gap = (!quiet_src && $urandom_range(0, 9) < 3) ? gap_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= DATA_W'(v);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
	endtask

	// setup phase, access phase held until pready, then back to idle
	task automatic reg_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// window_size write with junk above the field, then read it back
	task automatic set_window(input logic [WSIZE_W-1:0] w);
		logic [APB_DW-1:0] junk;
		junk = $urandom();
		reg_access(1'b1, ADDR_WSIZE, {junk[APB_DW-1:WSIZE_W], w});
		reg_access(1'b0, ADDR_WSIZE, '0);
		reg_writes++;
	endtask

	// wait for the last median, then wait out the extra settle time given by the caller
	task automatic drain_block(input int extra);
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (medians_due != 0);
		repeat (extra) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [WSIZE_W-1:0] w;
		int r;
		int phase_len;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of five: extremes, wrap, ties at the top and bottom
		quiet_src = 1'b1;
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(S_MIN);
		send_sample(S_MAX);
		send_sample(S_MAX);
		send_sample(S_ZERO);
		drain_block(SETTLE_CYCLES);

		// write past the register list is dropped, window keeps its contents
		reg_access(1'b1, ADDR_SPARE, APB_DW'(3));
		reg_access(1'b0, ADDR_WSIZE, '0);
		quiet_src = 1'b0;
		send_sample(S_NEG1);
		send_sample(SAMPLE_W'(1));
		drain_block(SETTLE_CYCLES);

		// size zero acts as one
		set_window('0);
		send_sample(SAMPLE_W'(-7));
		send_sample(S_MAX);
		drain_block(SETTLE_CYCLES);

		// all ones saturates to the full window, unwritten entries stay zero
		set_window('1);
		send_sample(S_MIN);
		send_sample(SAMPLE_W'(100));
		send_sample(SAMPLE_W'(-100));
		send_sample(S_MAX);
		drain_block(SETTLE_CYCLES);

		// even window takes the upper middle
		set_window(WSIZE_W'(2));
		send_sample(SAMPLE_W'(5));
		send_sample(SAMPLE_W'(-5));
		send_sample(SAMPLE_W'(7));
		send_sample(SAMPLE_W'(7));
		drain_block(SETTLE_CYCLES);

		// random phases, each under its own window setting
		while (samples_sent < RANDOM_ITEMS + 18) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				w = '0;
			else if (r < 16)
				w = WSIZE_W'(WINDOW_MAX_DEF);
			else if (r < 22)
				w = WSIZE_W'($urandom_range(WINDOW_MAX_DEF + 1, (1 << WSIZE_W) - 1));
			else if (r < 30)
				w = WSIZE_W'(1);
			else
				w = WSIZE_W'($urandom_range(2, WINDOW_MAX_DEF - 1));
			if ($urandom_range(0, 9) == 0)
				reg_access(1'b1, ADDR_SPARE, $urandom());
			set_window(w);
			quiet_src = ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(20, 120);
			repeat (phase_len)
				send_sample(pick_sample());
			drain_block(SETTLE_CYCLES);
		end

		drain_block(DRAIN_CYCLES);

		$display("covered %0d samples, %0d medians checked, %0d window_size writes",
			samples_sent, medians_seen, reg_writes);
		$display("sizes zero to oversize, even and odd windows, ties, extremes and stalls");
		if (mismatches == 0)
			$display("sliding_window_median_filter_tb passed");
		else
			$display("sliding_window_median_filter_tb failed");
		$finish;
	end

endmodule
